/* design/assert_macros.svh */
// Assertion macros shared by the line encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/ble_pkg.sv */
// Shared types and constants for the baseband line encoder.
`default_nettype none
package ble_pkg;

    localparam int DEFAULT_MAX_SPS = 64;

    localparam int MODE_W   = 2;
    localparam int AMP_W    = 15;
    localparam int SPS_W    = 7;
    localparam int PW_W     = 7;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [MODE_W-1:0] {
        MODE_RZ   = 2'd0,
        MODE_NRZ  = 2'd1,
        MODE_AMI  = 2'd2,
        MODE_HDB3 = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 2'd0,
        REG_AMPLITUDE = 2'd1,
        REG_SPS       = 2'd2,
        REG_PW        = 2'd3
    } cfg_reg_t;

    localparam mode_t            RST_MODE = MODE_NRZ;
    localparam logic [AMP_W-1:0] RST_AMP  = 15'd1000;
    localparam logic [SPS_W-1:0] RST_SPS  = 7'd8;
    localparam logic [PW_W-1:0]  RST_PW   = 7'd4;

endpackage
`default_nettype wire

/* design/ble_coder.sv */
// Line coder: turns one data bit into a pulse level and keeps the AMI/HDB3 state.
`default_nettype none
`include "assert_macros.svh"
module ble_coder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                accept,
    input  wire logic                                data_bit,
    input  ble_pkg::mode_t                           mode,
    input  wire logic [ble_pkg::AMP_W-1:0]           amplitude,
    output logic signed [ble_pkg::SAMPLE_W-1:0]      level
);
    import ble_pkg::*;

    localparam logic signed [1:0] SYM_POS  = 2'sb01;
    localparam logic signed [1:0] SYM_NEG  = 2'sb11;
    localparam logic signed [1:0] SYM_ZERO = 2'sb00;

    logic                nmn_reg, nmn_next;
    logic signed [1:0]   dc_reg, dc_next;
    logic [1:0]          zr_reg, zr_next;
    logic signed [1:0]   d0_reg, d1_reg, d2_reg;
    logic signed [1:0]   d0_next, d1_next, d2_next;

    logic signed [1:0]   pol;
    logic signed [1:0]   hdb3_sym;
    logic signed [1:0]   out_sym;
    logic signed [3:0]   dc_ext;
    logic signed [3:0]   pol_ext;
    logic signed [3:0]   dc_sum;
    logic signed [1:0]   dc_clamped;
    logic signed [SAMPLE_W-1:0] amp_pos;

    assign pol     = nmn_reg ? SYM_NEG : SYM_POS;
    assign dc_ext  = {{2{dc_reg[1]}}, dc_reg};
    assign pol_ext = {{2{pol[1]}}, pol};
    assign amp_pos = {1'b0, amplitude};

    // Saturate the running DC to -1..+1.
    always_comb
    begin
        if (dc_sum > 4'sd1)
        begin
            dc_clamped = SYM_POS;
        end
        else if (dc_sum < -4'sd1)
        begin
            dc_clamped = SYM_NEG;
        end
        else
        begin
            dc_clamped = dc_sum[1:0];
        end
    end

    // HDB3 coding of one bit through the three-symbol delay line.
    always_comb
    begin
        hdb3_sym = SYM_ZERO;
        dc_sum   = dc_ext;
        zr_next  = zr_reg;
        out_sym  = d0_reg;
        nmn_next = nmn_reg;
        if (data_bit)
        begin
            hdb3_sym = pol;
            nmn_next = !nmn_reg;
            dc_sum   = dc_ext + pol_ext;
            zr_next  = 2'd0;
        end
        else if (zr_reg == 2'd3)
        begin
            if (dc_reg != SYM_ZERO)
            begin
                // B00V: the oldest delayed zero becomes a balancing mark
                out_sym  = pol;
                hdb3_sym = pol;
                dc_sum   = dc_ext + {pol_ext[2:0], 1'b0};
                nmn_next = !nmn_reg;
            end
            else
            begin
                // 000V: violation of the last mark polarity
                hdb3_sym = -pol;
                dc_sum   = dc_ext - pol_ext;
            end
            zr_next = 2'd0;
        end
        else
        begin
            zr_next = zr_reg + 2'd1;
        end
        d0_next = d1_reg;
        d1_next = d2_reg;
        d2_next = hdb3_sym;
        dc_next = dc_clamped;
    end

    // Level for the current request, by mode.
    always_comb
    begin
        case (mode)
            MODE_RZ:
            begin
                level = data_bit ? amp_pos : '0;
            end
            MODE_NRZ:
            begin
                level = data_bit ? amp_pos : -amp_pos;
            end
            MODE_AMI:
            begin
                if (data_bit)
                begin
                    level = nmn_reg ? -amp_pos : amp_pos;
                end
                else
                begin
                    level = '0;
                end
            end
            MODE_HDB3:
            begin
                if (out_sym == SYM_POS)
                begin
                    level = amp_pos;
                end
                else if (out_sym == SYM_NEG)
                begin
                    level = -amp_pos;
                end
                else
                begin
                    level = '0;
                end
            end
            default:
            begin
                level = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nmn_reg <= 1'b0;
            dc_reg  <= SYM_ZERO;
            zr_reg  <= 2'd0;
            d0_reg  <= SYM_ZERO;
            d1_reg  <= SYM_ZERO;
            d2_reg  <= SYM_ZERO;
        end
        else if (accept)
        begin
            if (mode == MODE_HDB3)
            begin
                nmn_reg <= nmn_next;
                dc_reg  <= dc_next;
                zr_reg  <= zr_next;
                d0_reg  <= d0_next;
                d1_reg  <= d1_next;
                d2_reg  <= d2_next;
            end
            else if (mode == MODE_AMI && data_bit)
            begin
                nmn_reg <= !nmn_reg;
            end
        end
    end

    // Ternary symbols never take the unused code.
    `ASSERT_IMPL(a_dc_ternary, clk, rst_n, 1'b1, dc_reg != 2'sb10)
    `ASSERT_IMPL(a_delay_ternary, clk, rst_n, 1'b1,
        d0_reg != 2'sb10 && d1_reg != 2'sb10 && d2_reg != 2'sb10)

endmodule
`default_nettype wire

/* design/ble_serializer.sv */
// Symbol register and sample sequencer with a registered output stage.
`default_nettype none
`include "assert_macros.svh"
module ble_serializer #(
    parameter int MAX_SPS = ble_pkg::DEFAULT_MAX_SPS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic signed [ble_pkg::SAMPLE_W-1:0] load_level,
    input  wire logic [$clog2(MAX_SPS+1)-1:0]       load_pw,
    input  wire logic [$clog2(MAX_SPS+1)-1:0]       load_n,
    output logic                                    load_ready,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [ble_pkg::SAMPLE_W-1:0]     sample,
    output logic                                    last_sample
);
    import ble_pkg::*;

    localparam int N_W = $clog2(MAX_SPS + 1);

    logic                       sym_valid_reg, sym_valid_next;
    logic signed [SAMPLE_W-1:0] level_reg;
    logic [N_W-1:0]             pw_reg;
    logic [N_W-1:0]             n_reg;
    logic [N_W-1:0]             cnt_reg, cnt_next;
    logic [N_W-1:0]             cnt_inc;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic                       emit;
    logic                       is_last;

    assign cnt_inc    = cnt_reg + N_W'(1);
    assign is_last    = (cnt_inc == n_reg);
    assign emit       = sym_valid_reg && (!out_valid_reg || out_ready);
    assign load_ready = !sym_valid_reg || (emit && is_last);

    always_comb
    begin
        sym_valid_next = sym_valid_reg;
        cnt_next       = cnt_reg;
        if (emit)
        begin
            if (is_last)
            begin
                sym_valid_next = 1'b0;
                cnt_next       = '0;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
        if (load)
        begin
            sym_valid_next = 1'b1;
            cnt_next       = '0;
        end
        out_valid_next = emit || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sym_valid_reg <= sym_valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg <= load_level;
            pw_reg    <= load_pw;
            n_reg     <= load_n;
        end
        if (emit)
        begin
            sample_reg <= (cnt_reg < pw_reg) ? level_reg : '0;
            last_reg   <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign last_sample = last_reg;

    `ASSERT_IMPL(a_cnt_in_symbol, clk, rst_n, sym_valid_reg, cnt_reg < n_reg)
    `ASSERT_NEXT(a_symbol_done, clk, rst_n, emit && is_last && !load, !sym_valid_reg)
    `ASSERT_NEXT(a_load_restarts, clk, rst_n, load, sym_valid_reg && cnt_reg == '0)

endmodule
`default_nettype wire

/* design/baseband_line_encoder.sv */
// Top level of the baseband line encoder: configuration registers, coder and sequencer.
`default_nettype none
// Baseband line encoder. Each data_bit request becomes samples_per_symbol
// signed samples (one per cycle while out_ready is high, the final one
// flagged by last_sample) in one of four line codes: unipolar RZ, polar NRZ,
// bipolar AMI or HDB3. HDB3 output lags the input by three symbols because
// of its substitution delay line. An item passes through the combinational
// coder into the symbol register, and its samples then leave through the
// registered output stage. The symbol register takes the next bit in the
// cycle its last sample moves to the output register. samples_per_symbol is
// 8 after reset; zero acts as one, values above MAX_SPS act as MAX_SPS, and
// pulse_width saturates at the symbol length. Write configuration only while
// no symbol is in flight; the cfg port is always ready and an index selects
// mode, amplitude, samples_per_symbol or pulse_width in that order.
module baseband_line_encoder #(
    parameter int MAX_SPS = ble_pkg::DEFAULT_MAX_SPS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   data_bit,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [ble_pkg::SAMPLE_W-1:0]         sample,
    output logic                                        last_sample,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [ble_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [ble_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import ble_pkg::*;

    localparam int N_W   = $clog2(MAX_SPS + 1);
    localparam int CMP_W = (N_W > SPS_W) ? N_W : SPS_W;

    mode_t              mode_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic [SPS_W-1:0]   sps_reg;
    logic [PW_W-1:0]    pw_reg;

    logic               accept;
    logic               cfg_write;
    logic [CMP_W-1:0]   sps_ext;
    logic [CMP_W-1:0]   pw_ext;
    logic [CMP_W-1:0]   n_ext;
    logic [CMP_W-1:0]   pw_sat;
    logic [N_W-1:0]     n_eff;
    logic [N_W-1:0]     pw_eff;
    logic signed [SAMPLE_W-1:0] level;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = in_valid && in_ready;

    // Configuration registers; hold between writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= RST_MODE;
            amp_reg  <= RST_AMP;
            sps_reg  <= RST_SPS;
            pw_reg   <= RST_PW;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:      mode_reg <= mode_t'(cfg_data[MODE_W-1:0]);
                REG_AMPLITUDE: amp_reg  <= cfg_data[AMP_W-1:0];
                REG_SPS:       sps_reg  <= cfg_data[SPS_W-1:0];
                REG_PW:        pw_reg   <= cfg_data[PW_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective symbol length and pulse width.
    assign sps_ext = CMP_W'(sps_reg);
    assign pw_ext  = CMP_W'(pw_reg);

    always_comb
    begin
        if (sps_ext == '0)
        begin
            n_ext = CMP_W'(1);
        end
        else if (sps_ext > CMP_W'(MAX_SPS))
        begin
            n_ext = CMP_W'(MAX_SPS);
        end
        else
        begin
            n_ext = sps_ext;
        end
        pw_sat = (pw_ext > n_ext) ? n_ext : pw_ext;
    end

    assign n_eff  = n_ext[N_W-1:0];
    // Only RZ shortens the pulse; every other code holds the level all symbol.
    assign pw_eff = (mode_reg == MODE_RZ) ? pw_sat[N_W-1:0] : n_eff;

    ble_coder u_coder (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_bit  (data_bit),
        .mode      (mode_reg),
        .amplitude (amp_reg),
        .level     (level)
    );

    ble_serializer #(
        .MAX_SPS (MAX_SPS)
    ) u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .load_level  (level),
        .load_pw     (pw_eff),
        .load_n      (n_eff),
        .load_ready  (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .last_sample (last_sample)
    );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the baseband line encoder across all four line codes.
module testbench;
    import ble_pkg::*;

    localparam int MAX_SYMBOL_SAMPLES = DEFAULT_MAX_SPS;

    // One expected output sample: signed level and end-of-symbol flag.
    typedef struct {
        logic [SAMPLE_W-1:0] level;
        logic                closing;
    } line_sample_t;

    // Drive every block input to a known value from time zero.
    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       data_bit    = 1'b0;
    logic                       out_ready   = 1'b0;
    logic                       cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = REG_MODE;
    logic [CFG_DATA_W-1:0]      cfg_data    = '0;
    logic                       in_ready;
    logic                       out_valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
    logic                       cfg_ready;

    // Shadow copy of the configuration registers, reset values from the package.
    mode_t                      code_mode   = RST_MODE;
    logic [AMP_W-1:0]           pulse_amp   = RST_AMP;
    logic [SPS_W-1:0]           symbol_len  = RST_SPS;
    logic [PW_W-1:0]            rz_width    = RST_PW;

    // Shadow copy of the AMI/HDB3 coder state.
    logic                       mark_negative = 1'b0;
    int                         dc_balance    = 0;
    int                         zero_count    = 0;
    int                         hdb3_line [3] = '{0, 0, 0};

    line_sample_t               expected_samples [$];
    line_sample_t               head;
    int                         mismatches  = 0;
    bit                         steady_flow = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    baseband_line_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_bit    (data_bit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .last_sample (last_sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    function automatic void record_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    // Mirror a register write: keep only the bits the register holds.
    function automatic void apply_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_MODE:      code_mode  = mode_t'(value[MODE_W-1:0]);
            REG_AMPLITUDE: pulse_amp  = value[AMP_W-1:0];
            REG_SPS:       symbol_len = value[SPS_W-1:0];
            REG_PW:        rz_width   = value[PW_W-1:0];
            default:       ;
        endcase
    endfunction

    function automatic int clamp_balance(int v);
        if (v > 1)
            return 1;
        if (v < -1)
            return -1;
        return v;
    endfunction

    // Advance the HDB3 coder by one bit and return the ternary symbol leaving the
    // three-deep delay line. A fourth zero in a row becomes B00V when the running
    // balance is off (the parked zero three back turns into a mark), else 000V.
    function automatic int hdb3_advance(logic b);
        int pol;
        int sym;
        int leaving;
        pol = mark_negative ? -1 : 1;
        sym = 0;
        if (b)
        begin
            sym           = pol;
            mark_negative = !mark_negative;
            dc_balance    = clamp_balance(dc_balance + sym);
            zero_count    = 0;
        end
        else if (zero_count >= 3)
        begin
            if (dc_balance != 0)
            begin
                hdb3_line[0]  = pol;
                sym           = pol;
                dc_balance    = clamp_balance(dc_balance + 2 * pol);
                mark_negative = !mark_negative;
            end
            else
            begin
                sym        = -pol;
                dc_balance = clamp_balance(dc_balance + sym);
            end
            zero_count = 0;
        end
        else
        begin
            zero_count++;
        end
        leaving      = hdb3_line[0];
        hdb3_line[0] = hdb3_line[1];
        hdb3_line[1] = hdb3_line[2];
        hdb3_line[2] = sym;
        return leaving;
    endfunction

    // Queue the samples that one accepted data bit must produce.
    function automatic void encode_bit(logic b);
        int n;
        int width;
        int amp;
        int level;
        int k;
        line_sample_t s;
        n = int'(symbol_len);
        if (n < 1)
            n = 1;
        if (n > MAX_SYMBOL_SAMPLES)
            n = MAX_SYMBOL_SAMPLES;
        width = (int'(rz_width) > n) ? n : int'(rz_width);
        amp   = int'(pulse_amp);
        level = 0;
        case (code_mode)
            MODE_RZ:
                level = b ? amp : 0;
            MODE_NRZ:
            begin
                level = b ? amp : -amp;
                width = n;
            end
            MODE_AMI:
            begin
                // AMI flips the shared mark polarity but leaves the HDB3 balance alone.
                if (b)
                begin
                    level         = mark_negative ? -amp : amp;
                    mark_negative = !mark_negative;
                end
                width = n;
            end
            default:
            begin
                level = hdb3_advance(b) * amp;
                width = n;
            end
        endcase
        for (k = 0; k < n; k++)
        begin
            s.level   = (k < width) ? level[SAMPLE_W-1:0] : '0;
            s.closing = (k == n - 1);
            expected_samples.push_back(s);
        end
    endfunction

    // Check each accepted sample against the oldest expectation, then pick the
    // next cycle's out_ready: stall about a third of the time unless flow is steady.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
                record_mismatch($sformatf("sample %0d (last %0b) arrived with nothing expected",
                                          sample, last_sample));
            else
            begin
                head = expected_samples.pop_front();
                if (sample !== head.level || last_sample !== head.closing)
                    record_mismatch($sformatf("expected sample %0d last %0b, got %0d last %0b",
                                              $signed(head.level), head.closing,
                                              sample, last_sample));
            end
        end
        out_ready <= steady_flow || ($urandom_range(99) >= 32);
    end

    // Send one data bit request. Valid is left high after acceptance so a
    // back-to-back request never drops and raises it in the same step; a gap
    // lowers it first.
    task automatic send_bit(logic b);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 32)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_bit <= b;
        do
            @(posedge clk);
        while (!in_ready);
        encode_bit(b);
    endtask

    // Drop valid and hold until every expected sample has come out.
    task automatic settle_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_samples.size() != 0);
    endtask

    // Write all four registers while the block is idle. Upper data bits beyond
    // the mode, length and width registers are random to exercise the masking.
    task automatic configure(mode_t m, logic [AMP_W-1:0] amp, logic [SPS_W-1:0] sps,
                             logic [PW_W-1:0] pw);
        logic [CFG_DATA_W-1:0] words [4];
        cfg_reg_t              idx;
        int                    r;
        settle_outputs();
        words[0]               = CFG_DATA_W'($urandom);
        words[0][MODE_W-1:0]   = m;
        words[1]               = amp;
        words[2]               = CFG_DATA_W'($urandom);
        words[2][SPS_W-1:0]    = sps;
        words[3]               = CFG_DATA_W'($urandom);
        words[3][PW_W-1:0]     = pw;
        for (r = 0; r < 4; r++)
        begin
            idx = cfg_reg_t'(r);
            cfg_index <= idx;
            cfg_data  <= words[r];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            apply_register(idx, words[r]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Reset values: polar NRZ, amplitude 1000, eight samples per bit.
    task automatic test_power_on_defaults();
        send_bit(1'b1);
        send_bit(1'b0);
    endtask

    // RZ pulse shaping: zero width, partial width, and a width past the symbol.
    task automatic test_rz_pulse_shaping();
        configure(MODE_RZ, '1, 7'd4, 7'd0);
        send_bit(1'b1);
        send_bit(1'b0);
        configure(MODE_RZ, 15'd1234, 7'd5, 7'd2);
        send_bit(1'b1);
        send_bit(1'b1);
        configure(MODE_RZ, 15'd500, 7'd3, '1);
        send_bit(1'b1);
    endtask

    // Symbol length of zero acts as one; above the maximum it clamps.
    task automatic test_symbol_length_limits();
        configure(MODE_NRZ, '1, 7'd0, 7'd4);
        send_bit(1'b1);
        send_bit(1'b0);
        configure(MODE_NRZ, '0, '1, 7'd4);
        send_bit(1'b1);
        configure(MODE_NRZ, 15'd77, 7'd65, 7'd4);
        send_bit(1'b0);
    endtask

    // HDB3 000V with a balanced line, an AMI mark that skews the shared
    // polarity so the HDB3 balance saturates, then B00V, then flush the line.
    task automatic test_ami_hdb3_handover();
        configure(MODE_HDB3, 15'd300, 7'd2, 7'd1);
        repeat (4) send_bit(1'b0);
        configure(MODE_AMI, 15'd300, 7'd2, 7'd1);
        send_bit(1'b1);
        configure(MODE_HDB3, 15'd300, 7'd2, 7'd1);
        send_bit(1'b1);
        repeat (7) send_bit(1'b0);
    endtask

    // Phases cycle through the four codes with random settings. Traffic is
    // mostly zero runs of three to eight bits, most long enough to trigger
    // substitution, mixed with marks and plain random bits. One phase runs
    // without any idling, and one pauses mid-stream until all outputs drain.
    task automatic test_random_traffic();
        int               phase;
        int               sent;
        int               run;
        int               j;
        bit               paused;
        logic [AMP_W-1:0] amp;
        logic [SPS_W-1:0] sps;
        logic [PW_W-1:0]  pw;
        paused = 1'b0;
        for (phase = 0; phase < 12; phase++)
        begin
            amp = (phase == 2) ? '1 : (phase == 7) ? '0 : AMP_W'($urandom);
            sps = (phase == 5)  ? '0 :
                  (phase == 9)  ? '1 :
                  (phase == 10) ? SPS_W'(MAX_SYMBOL_SAMPLES) :
                                  SPS_W'($urandom_range(1, 12));
            pw  = (phase == 8) ? '1 : PW_W'($urandom_range(0, 14));
            configure(mode_t'(phase[1:0]), amp, sps, pw);
            steady_flow = (phase == 3);
            sent = 0;
            while (sent < ((phase == 3) ? 46 : 23))
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3:
                    begin
                        run = $urandom_range(3, 8);
                        for (j = 0; j < run; j++)
                            send_bit(1'b0);
                        sent += run;
                    end
                    4, 5, 6:
                    begin
                        send_bit(1'b1);
                        sent++;
                    end
                    default:
                    begin
                        send_bit(1'($urandom_range(1)));
                        sent++;
                    end
                endcase
                if (phase == 6 && sent >= 15 && !paused)
                begin
                    settle_outputs();
                    paused = 1'b1;
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_power_on_defaults();
        test_rz_pulse_shaping();
        test_symbol_length_limits();
        test_ami_hdb3_handover();
        test_random_traffic();
        settle_outputs();
        // Let any stray sample surface before the verdict.
        repeat (20) @(posedge clk);
        if (expected_samples.size() != 0)
            record_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Stop a hung run well past the slowest legal completion.
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/ble_pkg.sv
design/ble_coder.sv
design/ble_serializer.sv
design/baseband_line_encoder.sv
tb/sv/testbench.sv
